/* rtl/utf8_validating_decoder_core_assert.svh */
// Assertion macros for the UTF-8 decoder core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define UTF8VD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTF8VD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/utf8vd_pkg.sv */
// Shared types and constants for the UTF-8 validating decoder.
// No dependencies.
package utf8vd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;
  localparam int unsigned NUM_BYTES = 4;

  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] NONCHAR_LO = 21'h00FFFE;
  localparam logic [CP_W-1:0] NONCHAR_HI = 21'h00FFFF;
  localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;

  localparam logic [LEN_W-1:0] LEN_END = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THR = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOU = 3'd4;

  // per-byte classification from one lane
  typedef struct packed {
    logic       is_zero;
    logic       is_cont;
    logic       lead1;
    logic       lead2;
    logic       lead3;
    logic       lead4;
    logic [7:0] data;
  } byte_class_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] consumed;
    logic             bad_sequence;
    logic             at_end;
  } dec_result_t;

endpackage

/* rtl/utf8vd_byte_lane.sv */
// One byte lane: classifies a single byte of the window.
// Depends on utf8vd_pkg.
module utf8vd_byte_lane (
  input  logic [7:0]               byte_i,
  output utf8vd_pkg::byte_class_t  cls_o
);
  import utf8vd_pkg::*;

  always_comb begin
    cls_o.is_zero = (byte_i == 8'h00);
    cls_o.is_cont = ((byte_i & 8'hC0) == 8'h80);
    cls_o.lead1   = ~byte_i[7];
    cls_o.lead2   = ((byte_i & 8'hE0) == 8'hC0);
    cls_o.lead3   = ((byte_i & 8'hF0) == 8'hE0);
    cls_o.lead4   = ((byte_i & 8'hF8) == 8'hF0);
    cls_o.data    = byte_i;
  end

endmodule

/* rtl/utf8vd_merge.sv */
// Merge stage: combines the four lane classifications into one decoded word.
// Depends on utf8vd_pkg.
module utf8vd_merge (
  input  utf8vd_pkg::byte_class_t             cls_i [utf8vd_pkg::NUM_BYTES],
  input  logic [utf8vd_pkg::CP_W-1:0]         repl_i,
  output utf8vd_pkg::dec_result_t             res_o
);
  import utf8vd_pkg::*;

  logic [CP_W-1:0]  cp1, cp2, cp3, cp4, cp_sel;
  logic [LEN_W-1:0] len_sel;
  logic             ok2, ok3, ok4, form_ok, scalar_ok;

  assign cp1 = {13'd0, cls_i[0].data};
  assign cp2 = {10'd0, cls_i[0].data[4:0], cls_i[1].data[5:0]};
  assign cp3 = {5'd0, cls_i[0].data[3:0], cls_i[1].data[5:0], cls_i[2].data[5:0]};
  assign cp4 = {cls_i[0].data[2:0], cls_i[1].data[5:0], cls_i[2].data[5:0],
                cls_i[3].data[5:0]};

  assign ok2 = cls_i[0].lead2 & cls_i[1].is_cont;
  assign ok3 = cls_i[0].lead3 & cls_i[1].is_cont & cls_i[2].is_cont;
  assign ok4 = cls_i[0].lead4 & cls_i[1].is_cont & cls_i[2].is_cont & cls_i[3].is_cont;

  always_comb begin
    cp_sel  = '0;
    len_sel = LEN_END;
    if (cls_i[0].lead1) begin
      cp_sel  = cp1;
      len_sel = LEN_ONE;
    end else if (ok2) begin
      cp_sel  = cp2;
      len_sel = LEN_TWO;
    end else if (ok3) begin
      cp_sel  = cp3;
      len_sel = LEN_THR;
    end else if (ok4) begin
      cp_sel  = cp4;
      len_sel = LEN_FOU;
    end
  end

  assign form_ok   = (len_sel != LEN_END);
  assign scalar_ok = ~((cp_sel >= SURR_LO) && (cp_sel <= SURR_HI))
                   & (cp_sel != NONCHAR_LO) & (cp_sel != NONCHAR_HI)
                   & (cp_sel <= MAX_SCALAR);

  always_comb begin
    if (cls_i[0].is_zero) begin
      res_o.code_point   = '0;
      res_o.consumed     = LEN_END;
      res_o.bad_sequence = 1'b0;
      res_o.at_end       = 1'b1;
    end else if (form_ok && scalar_ok) begin
      res_o.code_point   = cp_sel;
      res_o.consumed     = len_sel;
      res_o.bad_sequence = 1'b0;
      res_o.at_end       = 1'b0;
    end else begin
      res_o.code_point   = repl_i;
      res_o.consumed     = LEN_ONE;
      res_o.bad_sequence = 1'b1;
      res_o.at_end       = 1'b0;
    end
  end

endmodule

/* rtl/utf8_validating_decoder_core.sv */
// UTF-8 validating decoder: four byte lanes, a merge stage, output register + skid.
// Each accepted window's result word is registered, or parked in the skid register on output stall.
// Throughput: one window per cycle while in_stall_o is low; the skid register absorbs one word on output stall.
// Reset (rst_ni low, async): output and skid empty, replacement point = U+FFFD.
// Depends on utf8vd_pkg, utf8vd_byte_lane, utf8vd_merge, the assert header.
`include "utf8_validating_decoder_core_assert.svh"
module utf8_validating_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [utf8vd_pkg::CP_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    byte0_i,
  input  logic [7:0]                    byte1_i,
  input  logic [7:0]                    byte2_i,
  input  logic [7:0]                    byte3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8vd_pkg::CP_W-1:0]   code_point_o,
  output logic [utf8vd_pkg::LEN_W-1:0]  consumed_o,
  output logic                          bad_sequence_o,
  output logic                          at_end_o
);
  import utf8vd_pkg::*;

  logic [7:0]      win [NUM_BYTES];
  byte_class_t     cls [NUM_BYTES];
  dec_result_t     res;
  logic [CP_W-1:0] repl_q;
  dec_result_t     out_q, out_d, skid_q, skid_d;
  logic            out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic            accept, out_take;

  assign win[0] = byte0_i;
  assign win[1] = byte1_i;
  assign win[2] = byte2_i;
  assign win[3] = byte3_i;

  for (genvar g = 0; g < NUM_BYTES; g++) begin : g_lane
    utf8vd_byte_lane u_lane (
      .byte_i (win[g]),
      .cls_o  (cls[g])
    );
  end

  utf8vd_merge u_merge (
    .cls_i  (cls),
    .repl_i (repl_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= REPL_RESET;
    end else if (cfg_we_i) begin
      repl_q <= cfg_data_i;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        // output word still held: park the new word
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = out_q.code_point;
  assign consumed_o     = out_q.consumed;
  assign bad_sequence_o = out_q.bad_sequence;
  assign at_end_o       = out_q.at_end;

  `UTF8VD_ASSERT_IMP(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `UTF8VD_ASSERT_IMP(a_bad_one_byte, out_valid_q && bad_sequence_o, (consumed_o == LEN_ONE) && !at_end_o, "bad word not one byte")
  `UTF8VD_ASSERT_IMP(a_end_zero, out_valid_q && at_end_o, (consumed_o == LEN_END) && (code_point_o == '0) && !bad_sequence_o, "end word malformed")
  `UTF8VD_ASSERT_NXT(a_park_on_stall, accept && out_valid_q && out_stall_i, skid_valid_q, "stalled accept not parked")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for utf8_validating_decoder_core: directed and random byte windows,
// replacement point changes, random idle/stall and a long output hold-off.
// Depends on utf8vd_pkg and the core RTL.
module tb_top;
  import utf8vd_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CP_W-1:0]  cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       byte0_i;
  logic [7:0]       byte1_i;
  logic [7:0]       byte2_i;
  logic [7:0]       byte3_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [CP_W-1:0]  code_point_o;
  logic [LEN_W-1:0] consumed_o;
  logic             bad_sequence_o;
  logic             at_end_o;

  utf8_validating_decoder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte0_i        (byte0_i),
    .byte1_i        (byte1_i),
    .byte2_i        (byte2_i),
    .byte3_i        (byte3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o),
    .consumed_o     (consumed_o),
    .bad_sequence_o (bad_sequence_o),
    .at_end_o       (at_end_o)
  );

  dec_result_t     predicted_chars [$];
  logic [CP_W-1:0] repl_point;
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  int              hold_req = 0;
  int              fail_count = 0;
  int              windows_in = 0;
  int              chars_out = 0;
  int              bad_seen = 0;
  int              end_seen = 0;
  int              repl_writes = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words still pending", predicted_chars.size());
    $display("tb_top failed");
    $finish;
  end

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // golden decode of one window
  function automatic dec_result_t decode_window(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [7:0] b3,
                                                input logic [CP_W-1:0] repl);
    dec_result_t      r;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             c1, c2, c3;
    c1 = (b1[7:6] == 2'b10);
    c2 = (b2[7:6] == 2'b10);
    c3 = (b3[7:6] == 2'b10);
    r = '0;
    if (b0 == 8'h00) begin
      r.consumed = LEN_END;
      r.at_end = 1'b1;
      return r;
    end
    cp = '0;
    len = LEN_END;
    if (!b0[7]) begin
      cp = {14'b0, b0[6:0]};
      len = LEN_ONE;
    end else if (b0[7:5] == 3'b110 && c1) begin
      cp = {10'b0, b0[4:0], b1[5:0]};
      len = LEN_TWO;
    end else if (b0[7:4] == 4'b1110 && c1 && c2) begin
      cp = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
      len = LEN_THR;
    end else if (b0[7:3] == 5'b11110 && c1 && c2 && c3) begin
      cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      len = LEN_FOU;
    end
    if (len != LEN_END && !(cp >= SURR_LO && cp <= SURR_HI) && cp != NONCHAR_LO &&
        cp != NONCHAR_HI && cp <= MAX_SCALAR) begin
      r.code_point = cp;
      r.consumed = len;
    end else begin
      r.code_point = repl;
      r.consumed = LEN_ONE;
      r.bad_sequence = 1'b1;
    end
    return r;
  endfunction

  // receiver: random stall, or a counted hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= roll(stall_pct);
      end
    end
  end

  // predict on every accepted window, check every accepted result word
  always @(posedge clk_i) begin
    dec_result_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_chars.push_back(decode_window(byte0_i, byte1_i, byte2_i, byte3_i,
                                                repl_point));
        windows_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        got.code_point = code_point_o;
        got.consumed = consumed_o;
        got.bad_sequence = bad_sequence_o;
        got.at_end = at_end_o;
        chars_out++;
        bad_seen += got.bad_sequence;
        end_seen += got.at_end;
        if (predicted_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: unexpected word cp=%h len=%0d bad=%b end=%b", $time,
                     got.code_point, got.consumed, got.bad_sequence, got.at_end);
        end else begin
          want = predicted_chars.pop_front();
          if (got.code_point !== want.code_point || got.consumed !== want.consumed ||
              got.bad_sequence !== want.bad_sequence || got.at_end !== want.at_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%t: mismatch exp cp=%h len=%0d bad=%b end=%b,",
                        " got cp=%h len=%0d bad=%b end=%b"},
                       $time, want.code_point, want.consumed, want.bad_sequence, want.at_end,
                       got.code_point, got.consumed, got.bad_sequence, got.at_end);
          end
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3);
    while (roll(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte0_i <= b0;
    byte1_i <= b1;
    byte2_i <= b2;
    byte3_i <= b3;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait until every predicted word has come out
  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    while (predicted_chars.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_repl(input logic [CP_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    repl_point = value;
    repl_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed sequences with random payload, some broken, some noise
  task automatic send_random(input int n);
    logic [7:0] w [4];
    int         kind;
    int         pos;
    repeat (n) begin
      for (int i = 0; i < 4; i++) w[i] = 8'($urandom_range(255));
      kind = $urandom_range(99);
      if (kind < 4) begin
        w[0] = 8'h00;
      end else if (kind < 18) begin
        w[0][7] = 1'b0;
      end else if (kind < 36) begin
        w[0][7:5] = 3'b110;
        w[1][7:6] = 2'b10;
      end else if (kind < 56) begin
        w[0][7:4] = 4'b1110;
        w[1][7:6] = 2'b10;
        w[2][7:6] = 2'b10;
        if (roll(20)) begin
          // surrogate range
          w[0] = 8'hED;
          w[1][5] = 1'b1;
        end else if (roll(15)) begin
          // U+FFFE / U+FFFF
          w[0] = 8'hEF;
          w[1] = 8'hBF;
          w[2][5:1] = 5'b11111;
        end
      end else if (kind < 76) begin
        w[0][7:3] = 5'b11110;
        w[1][7:6] = 2'b10;
        w[2][7:6] = 2'b10;
        w[3][7:6] = 2'b10;
        if (roll(30)) w[0] = 8'hF4;
      end else if (kind < 90) begin
        // multi-byte lead with one bad continuation
        pos = $urandom_range(1, 3);
        w[0][7:3] = 5'b11110;
        if (pos < 3 && roll(50)) w[0][7:4] = 4'b1110;
        if (pos < 2 && roll(50)) w[0][7:5] = 3'b110;
        for (int i = 1; i < 4; i++) w[i][7:6] = 2'b10;
        while (w[pos][7:6] == 2'b10) w[pos][7:6] = 2'($urandom_range(3));
      end
      send_word(w[0], w[1], w[2], w[3]);
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_word(8'h00, 8'h00, 8'h00, 8'h00);
    send_word(8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_word(8'h01, 8'h00, 8'h00, 8'h00);
    send_word(8'h7F, 8'hFF, 8'hFF, 8'hFF);
    send_word(8'hC0, 8'h80, 8'h00, 8'h00);  // overlong, accepted
    send_word(8'hC2, 8'hA9, 8'h41, 8'h42);
    send_word(8'hDF, 8'hBF, 8'hFF, 8'hFF);
    send_word(8'hE0, 8'h80, 8'h80, 8'h00);
    send_word(8'hE2, 8'h82, 8'hAC, 8'h00);
    send_word(8'hED, 8'h9F, 8'hBF, 8'h00);
    send_word(8'hED, 8'hA0, 8'h80, 8'h00);
    send_word(8'hED, 8'hBF, 8'hBF, 8'h00);
    send_word(8'hEF, 8'hBF, 8'hBD, 8'h00);
    send_word(8'hEF, 8'hBF, 8'hBE, 8'h00);
    send_word(8'hEF, 8'hBF, 8'hBF, 8'h00);
    send_word(8'hF0, 8'h90, 8'h80, 8'h80);
    send_word(8'hF4, 8'h8F, 8'hBF, 8'hBF);
    send_word(8'hF4, 8'h90, 8'h80, 8'h80);
    send_word(8'hF7, 8'hBF, 8'hBF, 8'hBF);
    send_word(8'h80, 8'h80, 8'h80, 8'h80);  // lone continuation
    send_word(8'hC2, 8'h41, 8'h00, 8'h00);
    send_word(8'hE2, 8'h82, 8'h41, 8'h00);
    send_word(8'hF0, 8'h90, 8'h80, 8'hC0);
    send_word(8'hF8, 8'h80, 8'h80, 8'h80);
    send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain_decoder();
  endtask

  task automatic test_replacement_values();
    logic [CP_W-1:0] vals [5];
    vals[0] = '0;
    vals[1] = MAX_SCALAR;
    vals[2] = SURR_LO;  // not a scalar value, still emitted as is
    vals[3] = CP_W'($urandom_range(MAX_SCALAR));
    vals[4] = REPL_RESET;
    send_idle_pct = 18;
    stall_pct = 18;
    foreach (vals[i]) begin
      write_repl(vals[i]);
      send_random(40);
      drain_decoder();
    end
  endtask

  task automatic test_idle_mix();
    int send_pcts [4] = '{0, 59, 0, 18};
    int stall_pcts [4] = '{0, 0, 59, 18};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      stall_pct = stall_pcts[p];
      send_random(210);
    end
    drain_decoder();
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 200;
    send_random(30);
    drain_decoder();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 18;
    stall_pct = 18;
    send_random(20);
    drain_decoder();
    send_random(20);
    drain_decoder();
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    byte0_i <= '0;
    byte1_i <= '0;
    byte2_i <= '0;
    byte3_i <= '0;
    repl_point = REPL_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_replacement_values();
    test_idle_mix();
    test_output_holdoff();
    test_sender_pause();
    drain_decoder();
    repeat (10) @(posedge clk_i);
    $display("decoded %0d windows into %0d words (%0d replaced, %0d end markers)",
             windows_in, chars_out, bad_seen, end_seen);
    $display("%0d replacement point writes, %0d failures", repl_writes, fail_count);
    if (fail_count == 0 && predicted_chars.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/utf8vd_pkg.sv
rtl/utf8vd_byte_lane.sv
rtl/utf8vd_merge.sv
rtl/utf8_validating_decoder_core.sv
test/tb_top.sv
